/* src/arm_pkg.sv */
`default_nettype none

package arm_pkg;

  localparam int MaxRangesDef     = 16;
  localparam int TurnFracBitsDef  = 24;

  localparam int AngleW   = 32;
  localparam int SlotW    = 4;
  localparam int CountW   = 5;
  localparam int TolW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_COUNTER_CLOCKWISE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANGES_IN_USE     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE         = 2'd2;

  typedef struct packed {
    logic                     op;
    logic [SlotW-1:0]         slot;
    logic signed [AngleW-1:0] range_low;
    logic signed [AngleW-1:0] range_high;
    logic signed [AngleW-1:0] angle;
    logic                     final_query;
  } arm_req_t;

  typedef struct packed {
    logic in_range;
    logic final_res;
  } arm_res_t;

  typedef struct packed {
    logic              counter_clockwise;
    logic [CountW-1:0] ranges_in_use;
    logic [TolW-1:0]   tolerance;
  } arm_cfg_t;

  typedef struct packed {
    logic     valid;
    logic     hit;
    arm_req_t req;
  } arm_stage_t;

endpackage

`default_nettype wire

/* src/angular_range_membership_top.sv */
// Angular range membership test. Ranges are loaded into slots and queries
// test one angle against the first ranges_in_use slots; both kinds of request
// share one input channel and run through a chain of MAX_RANGES cells, one
// slot per cell, in request order. One request is taken per cycle while the
// output is not stalled; a query passes through the cell chain and then the
// output register before its answer appears. A stalled output holds the whole
// chain. Configuration must be written only while no request is in flight;
// the block itself does not enforce this.
`default_nettype none

module angular_range_membership_top #(
  parameter int MAX_RANGES         = arm_pkg::MaxRangesDef,
  parameter int TURN_FRACTION_BITS = arm_pkg::TurnFracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [arm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [arm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire arm_pkg::arm_req_t             in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output arm_pkg::arm_res_t                  out_res_o
);
  import arm_pkg::*;

  arm_cfg_t   cfg_q;
  arm_stage_t chain [MAX_RANGES+1];
  logic       en;
  logic       out_valid_q;
  arm_res_t   out_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{counter_clockwise: 1'b1, ranges_in_use: '0, tolerance: 16'd921};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COUNTER_CLOCKWISE: cfg_q.counter_clockwise <= cfg_data_i[0];
        CFG_RANGES_IN_USE:     cfg_q.ranges_in_use     <= cfg_data_i[CountW-1:0];
        CFG_TOLERANCE:         cfg_q.tolerance         <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  assign chain[0] = '{valid: in_valid_i, hit: 1'b0, req: in_req_i};

  for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
    arm_cell #(
      .SlotIdx      (j),
      .TurnFracBits (TURN_FRACTION_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .cfg_i   (cfg_q),
      .stage_i (chain[j]),
      .stage_o (chain[j+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[MAX_RANGES].valid && (chain[MAX_RANGES].req.op == OP_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= '{in_range: chain[MAX_RANGES].hit,
                 final_res: chain[MAX_RANGES].req.final_query};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && chain[MAX_RANGES].valid && chain[MAX_RANGES].req.op == OP_LOAD)
      |=> !out_valid_q)
    else $error("load request produced a result");

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && chain[MAX_RANGES].valid && chain[MAX_RANGES].req.op == OP_QUERY)
      |=> (out_valid_q && out_q.final_res == $past(chain[MAX_RANGES].req.final_query)
           && out_q.in_range == $past(chain[MAX_RANGES].hit)))
    else $error("query result lost or altered");

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(chain[MAX_RANGES].valid) && $stable(chain[MAX_RANGES].hit)))
    else $error("chain advanced during stall");

endmodule

`default_nettype wire

/* src/arm_cell.sv */
`default_nettype none

module arm_cell #(
  parameter int SlotIdx      = 0,
  parameter int TurnFracBits = arm_pkg::TurnFracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire arm_pkg::arm_cfg_t  cfg_i,
  input  wire arm_pkg::arm_stage_t stage_i,
  output arm_pkg::arm_stage_t     stage_o
);
  import arm_pkg::*;

  localparam int CW = (TurnFracBits + 2 > 18) ? TurnFracBits + 2 : 18;

  logic [TurnFracBits-1:0] lo_q, hi_q;
  logic                    valid_q;
  logic                    hit_q;
  arm_req_t                req_q;

  logic [TurnFracBits-1:0] start, stop, span, off;
  logic [CW-1:0]           span_w, off_w, tol_w, rest_w;
  logic                    active, slot_hit, load_here, hit_d;

  assign active    = 32'(cfg_i.ranges_in_use) > 32'(SlotIdx);
  assign load_here = stage_i.valid && (stage_i.req.op == OP_LOAD)
                     && (32'(stage_i.req.slot) == 32'(SlotIdx));

  always_comb begin
    start    = cfg_i.counter_clockwise ? lo_q : hi_q;
    stop     = cfg_i.counter_clockwise ? hi_q : lo_q;
    span     = stop - start;
    off      = stage_i.req.angle[TurnFracBits-1:0] - start;
    span_w   = CW'(span);
    off_w    = CW'(off);
    tol_w    = CW'(cfg_i.tolerance);
    rest_w   = (CW'(1) << TurnFracBits) - span_w;
    slot_hit = (span_w < tol_w) || (rest_w < tol_w) || (off_w <= span_w + tol_w);
    hit_d    = stage_i.hit
               || (stage_i.valid && (stage_i.req.op == OP_QUERY) && active && slot_hit);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && load_here) begin
      lo_q <= stage_i.req.range_low[TurnFracBits-1:0];
      hi_q <= stage_i.req.range_high[TurnFracBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
      req_q <= stage_i.req;
    end
  end

  assign stage_o = '{valid: valid_q, hit: hit_q, req: req_q};

endmodule

`default_nettype wire
